// ----- rtl/pvs_row_rle_decoder_macros.svh -----
// assertion macros for the visibility row decoder
// used by the job queue and the result stage; no other dependencies
`ifndef PVS_ROW_RLE_DECODER_MACROS_SVH
`define PVS_ROW_RLE_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PVS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pvs assertion failed");
// condition must never be true out of reset
`define PVS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pvs forbidden condition seen");
`else
`define PVS_ASSERT(lbl, clk, rst_n, prop)
`define PVS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- rtl/pvs_pkg.sv -----
// shared types and constants for the visibility row decoder
// no dependencies
package pvs_pkg;

    localparam int LEAF_W       = 14;
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 14;
    localparam int MAX_LEAVES_D = 8192;
    localparam int JOB_DEPTH    = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIS_LEAF_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIS_PRESENT    = 2'd2;

    // result kinds
    localparam logic KIND_LEAF  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // one classified byte handed from front to back
    typedef struct packed {
        logic [LEAF_W-1:0] base;
        logic [BYTE_W-1:0] mask;
        logic              err;
    } t_job;

endpackage

// ----- rtl/pvs_row_rle_decoder.sv -----
// visibility row decoder: byte in, one result per visible leaf or an end-of-data error out
// path: a byte's job is written to the job queue, then loaded into the result walker,
// whose results leave through the output register; bytes are taken one per cycle while
// the queue has room; up to 8 results per byte leave one per cycle unless stalled
// reset: synchronous active low; counter 1, row idle, registers 0, queue empty
module pvs_row_rle_decoder
    import pvs_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_D
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_vis_byte,
    input  logic                  i_row_start,
    input  logic                  i_end_of_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [LEAF_W-1:0]     o_leaf_index,
    output logic                  o_result_kind,
    output logic                  o_last_of_byte
);

    logic accept;
    logic push;
    t_job push_job;
    logic fifo_full;
    logic fifo_vld;
    t_job pop_job;
    logic pop;

    // input transfer
    assign o_in_stall = fifo_full;
    assign accept     = i_in_valid && !fifo_full;

    pvs_front #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_vis_byte    (i_vis_byte),
        .i_row_start   (i_row_start),
        .i_end_of_data (i_end_of_data),
        .o_push        (push),
        .o_job         (push_job)
    );

    pvs_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_valid (fifo_vld),
        .o_job   (pop_job)
    );

    pvs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (fifo_vld),
        .i_job          (pop_job),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_leaf_index   (o_leaf_index),
        .o_result_kind  (o_result_kind),
        .o_last_of_byte (o_last_of_byte)
    );

endmodule

// ----- rtl/pvs_front.sv -----
// front end: configuration registers, row state and byte classification
// depends on pvs_pkg
module pvs_front
    import pvs_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_D
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [BYTE_W-1:0]     i_vis_byte,
    input  logic                  i_row_start,
    input  logic                  i_end_of_data,
    output logic                  o_push,
    output t_job                  o_job
);

    logic [LEAF_W-1:0] r_leaf_count;
    logic [LEAF_W-1:0] r_vis_leaf_limit;
    logic              r_vis_present;
    logic [LEAF_W-1:0] r_next_leaf;
    logic              r_skip_pending;
    logic              r_row_active;

    logic [LEAF_W-1:0] n_next_leaf;
    logic              n_skip_pending;
    logic              n_row_active;

    logic [LEAF_W-1:0] eff_count;
    logic [LEAF_W-1:0] cur_leaf;
    logic              cur_skip;
    logic              cur_active;
    logic [LEAF_W:0]   sum_skip;
    logic [LEAF_W:0]   sum_byte;
    logic [LEAF_W-1:0] adv_skip;
    logic [LEAF_W-1:0] adv_byte;
    logic [BYTE_W-1:0] vis_mask;
    logic              job_vld;
    t_job              job;

    // effective leaf count, clipped to the build limit
    assign eff_count = (32'(r_leaf_count) >= MAX_LEAVES) ? LEAF_W'(MAX_LEAVES)
                                                         : r_leaf_count;

    // a row start restarts the counter before the byte is looked at
    assign cur_leaf   = i_row_start ? LEAF_W'(1) : r_next_leaf;
    assign cur_skip   = i_row_start ? 1'b0 : r_skip_pending;
    assign cur_active = i_row_start | r_row_active;

    // saturating counter advances
    assign sum_skip = {1'b0, cur_leaf} + {4'b0, i_vis_byte, 3'b000};
    assign sum_byte = {1'b0, cur_leaf} + (LEAF_W+1)'(8);
    assign adv_skip = sum_skip[LEAF_W] ? '1 : sum_skip[LEAF_W-1:0];
    assign adv_byte = sum_byte[LEAF_W] ? '1 : sum_byte[LEAF_W-1:0];

    // per-bit visibility tests, each bit independent
    always_comb begin
        logic [LEAF_W:0] lf;
        for (int b = 0; b < BYTE_W; b++) begin
            lf = {1'b0, cur_leaf} + (LEAF_W+1)'(b);
            vis_mask[b] = i_vis_byte[b] && (lf < {1'b0, eff_count})
                          && (lf <= {1'b0, r_vis_leaf_limit});
        end
    end

    // row state update and job build
    always_comb begin
        n_next_leaf    = r_next_leaf;
        n_skip_pending = r_skip_pending;
        n_row_active   = r_row_active;
        job_vld        = 1'b0;
        job.base       = cur_leaf;
        job.mask       = vis_mask;
        job.err        = 1'b0;
        if (!r_vis_present) begin
            n_row_active = 1'b0;
        end else begin
            n_next_leaf    = cur_leaf;
            n_skip_pending = cur_skip;
            n_row_active   = cur_active;
            if (cur_active) begin
                if (cur_leaf >= eff_count) begin
                    n_row_active = 1'b0;
                end else begin
                    if (cur_skip) begin
                        n_skip_pending = 1'b0;
                        n_next_leaf    = adv_skip;
                    end else if (i_vis_byte == '0) begin
                        if (i_end_of_data) begin
                            job_vld  = 1'b1;
                            job.base = '0;
                            job.mask = BYTE_W'(1);
                            job.err  = 1'b1;
                        end else begin
                            n_skip_pending = 1'b1;
                        end
                    end else begin
                        job_vld     = |vis_mask;
                        n_next_leaf = adv_byte;
                    end
                    if (i_end_of_data || (n_next_leaf >= eff_count)) begin
                        n_row_active   = 1'b0;
                        n_skip_pending = 1'b0;
                    end
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count     <= '0;
            r_vis_leaf_limit <= '0;
            r_vis_present    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEAF_COUNT:     r_leaf_count     <= i_cfg_data[LEAF_W-1:0];
                CFG_VIS_LEAF_LIMIT: r_vis_leaf_limit <= i_cfg_data[LEAF_W-1:0];
                CFG_VIS_PRESENT:    r_vis_present    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // row state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_leaf    <= LEAF_W'(1);
            r_skip_pending <= 1'b0;
            r_row_active   <= 1'b0;
        end else if (i_accept) begin
            r_next_leaf    <= n_next_leaf;
            r_skip_pending <= n_skip_pending;
            r_row_active   <= n_row_active;
        end
    end

    assign o_push = i_accept & job_vld;
    assign o_job  = job;

endmodule

// ----- rtl/pvs_job_fifo.sv -----
// short job queue between classification and result generation
// depends on pvs_pkg and the assertion macro header
`include "pvs_row_rle_decoder_macros.svh"
module pvs_job_fifo
    import pvs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = $clog2(JOB_DEPTH);
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    t_job             r_mem [JOB_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == JOB_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == JOB_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (32'(r_count) == JOB_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    `PVS_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full && !i_pop)
    `PVS_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && !o_valid)

endmodule

// ----- rtl/pvs_back.sv -----
// back end: walks a job's mask and issues one result per cycle unless the output is stalled
// depends on pvs_pkg and the assertion macro header
`include "pvs_row_rle_decoder_macros.svh"
module pvs_back
    import pvs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [LEAF_W-1:0] o_leaf_index,
    output logic              o_result_kind,
    output logic              o_last_of_byte
);

    localparam int IDX_W = $clog2(BYTE_W);

    logic              r_act;
    logic [LEAF_W-1:0] r_base;
    logic [BYTE_W-1:0] r_mask;
    logic              r_err;
    logic              r_out_vld;
    logic [LEAF_W-1:0] r_out_leaf;
    logic              r_out_kind;
    logic              r_out_last;

    logic              slot_free;
    logic              emit;
    logic [IDX_W-1:0]  bit_idx;
    logic [BYTE_W-1:0] rest;
    logic              last;

    // lowest set bit of the remaining mask
    always_comb begin
        bit_idx = '0;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            if (r_mask[b]) begin
                bit_idx = IDX_W'(b);
            end
        end
    end

    assign rest      = r_mask & (r_mask - 1'b1);
    assign last      = (rest == '0);
    assign slot_free = !r_out_vld || !i_out_stall;
    assign emit      = slot_free && r_act;
    assign o_pop     = i_job_valid && (!r_act || (emit && last));

    // job walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (o_pop) begin
            r_act <= 1'b1;
        end else if (emit) begin
            r_act <= !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_base <= i_job.base;
            r_mask <= i_job.mask;
            r_err  <= i_job.err;
        end else if (emit) begin
            r_mask <= rest;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (slot_free) begin
            r_out_vld <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_leaf <= r_err ? '0 : r_base + LEAF_W'(bit_idx);
            r_out_kind <= r_err ? KIND_ERROR : KIND_LEAF;
            r_out_last <= last;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_leaf_index   = r_out_leaf;
    assign o_result_kind  = r_out_kind;
    assign o_last_of_byte = r_out_last;

    `PVS_ASSERT(a_active_has_bits, i_clk, i_rst_n, r_act |-> (r_mask != '0))
    `PVS_ASSERT(a_error_shape, i_clk, i_rst_n, (r_out_vld && r_out_kind == KIND_ERROR) |-> (r_out_last && r_out_leaf == '0))

endmodule
